// File: src/fdv_pkg.sv
`default_nettype none

package fdv_pkg;

   localparam int MAX_SAMPLES  = 65536;
   localparam int SAMPLE_LIMIT = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;
   localparam int IDX_W        = 16;
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(SAMPLE_LIMIT - 1);

   localparam int POS_W      = 32;
   localparam int WIN_DEPTH  = 4;
   localparam int AXES       = 3;

   // result queue; pipeline plus queue never hold more than FIFO_DEPTH results
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int DERIV_STAGES = 5;

   // derivative datapath widths
   localparam int NUM_W      = 37;
   localparam int INV_HALF_W = 16;
   localparam int PP_W       = NUM_W + INV_HALF_W + 1;
   localparam int FULL_W     = PP_W + INV_HALF_W;
   localparam int Q_W        = 36;
   localparam int U_W        = Q_W + 1;
   localparam int DIFF_W     = Q_W + 2;
   localparam int SHIFT_D2   = INV_HALF_W + 1;
   localparam int SHIFT_D12  = INV_HALF_W + 2;
   localparam int RND_D2     = 1 << INV_HALF_W;
   localparam int RND_D12    = 3 << (INV_HALF_W + 1);

   // floor(u / 3) = (u * DIV3_MUL) >> DIV3_SHIFT for u < 2**37
   localparam int DIV3_SHIFT = 38;
   localparam int DIV3_SPLIT = 18;
   localparam logic [U_W-1:0] DIV3_MUL = 37'h15_5555_5556;
   localparam int PH_W       = U_W + (U_W - DIV3_SPLIT);
   localparam int PL_W       = U_W + DIV3_SPLIT;
   localparam int DPROD_W    = PH_W + DIV3_SPLIT;
   localparam logic signed [U_W-1:0] DIV3_OFFSET = U_W'(3) << (Q_W - 2);
   localparam logic signed [Q_W-1:0] DIV3_BIAS   = Q_W'(1) << (Q_W - 2);

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_TIME_STEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIND_SPEED    = 1'd1;
   localparam logic [31:0] INV_TIME_STEP_RESET = 32'h0001_0000;

   typedef enum logic [1:0] {
      KIND_FORWARD,
      KIND_CENTRAL,
      KIND_FIVE_POINT,
      KIND_BACKWARD
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH_CENTRAL,
      ST_FLUSH_BACKWARD
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             fin;
   } meta_type;

   typedef struct packed {
      logic signed [POS_W-1:0] vel_x;
      logic signed [POS_W-1:0] vel_y;
      logic signed [POS_W-1:0] vel_z;
      logic [IDX_W-1:0]        idx;
      logic                    fin;
   } result_type;

   // stencil numerator; w0 is the newest sample held in the window
   function automatic logic signed [NUM_W-1:0] stencil_num(
      input kind_type                kind,
      input logic signed [POS_W-1:0] p_new,
      input logic signed [POS_W-1:0] w0,
      input logic signed [POS_W-1:0] w1,
      input logic signed [POS_W-1:0] w2,
      input logic signed [POS_W-1:0] w3
   );
      logic signed [NUM_W-1:0] en, e0, e1, e2, e3, res;
      en = NUM_W'(p_new);
      e0 = NUM_W'(w0);
      e1 = NUM_W'(w1);
      e2 = NUM_W'(w2);
      e3 = NUM_W'(w3);
      case (kind)
         KIND_FORWARD:    res = (e0 <<< 2) - (e1 <<< 1) - e1 - en;
         KIND_CENTRAL:    res = e0 - e2;
         KIND_FIVE_POINT: res = (e0 <<< 3) - (e2 <<< 3) + e3 - en;
         KIND_BACKWARD:   res = (e0 <<< 1) + e0 - (e1 <<< 2) + e2;
         default:         res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/fdv_deriv.sv
`default_nettype none

module fdv_deriv (
   input  wire logic                                clock,
   input  wire logic signed [fdv_pkg::NUM_W-1:0]    num,
   input  wire logic                                d12,
   input  wire logic signed [fdv_pkg::POS_W-1:0]    bias,
   input  wire logic [31:0]                         inv_step,
   output logic signed [fdv_pkg::POS_W-1:0]         vel
);

   logic signed [fdv_pkg::INV_HALF_W:0] inv_hi_s, inv_lo_s;

   logic signed [fdv_pkg::PP_W-1:0]   hi_ff, hi_in, lo_ff, lo_in;
   logic                              d12_1_ff, d12_2_ff, d12_3_ff;
   logic signed [fdv_pkg::FULL_W-1:0] sum_c, qw_c;
   logic [fdv_pkg::FULL_W-fdv_pkg::Q_W:0] qw_top;
   logic signed [fdv_pkg::Q_W-1:0]    q2_ff, q2_in, q3_ff;
   logic signed [fdv_pkg::U_W-1:0]    u_s;
   logic [fdv_pkg::U_W-1:0]           u_c;
   logic [fdv_pkg::PH_W-1:0]          ph_ff, ph_in;
   logic [fdv_pkg::PL_W-1:0]          pl_ff, pl_in;
   logic [fdv_pkg::DPROD_W-1:0]       dprod_c;
   logic signed [fdv_pkg::Q_W-1:0]    dv_ff, dv_in;
   logic signed [fdv_pkg::DIFF_W-1:0] diff_c;
   logic [fdv_pkg::DIFF_W-fdv_pkg::POS_W:0] diff_top;
   logic signed [fdv_pkg::POS_W-1:0]  vel_ff, vel_in;

   // stage 1: N * inv_step as two half products
   assign inv_hi_s = {1'b0, inv_step[31:16]};
   assign inv_lo_s = {1'b0, inv_step[15:0]};
   assign hi_in    = num * inv_hi_s;
   assign lo_in    = num * inv_lo_s;

   // stage 2: full product, rounding, scale by 1/(2*65536) or 1/(4*65536), clamp
   always_comb begin
      sum_c = (fdv_pkg::FULL_W'(hi_ff) <<< fdv_pkg::INV_HALF_W) + fdv_pkg::FULL_W'(lo_ff)
            + (d12_1_ff ? fdv_pkg::FULL_W'(fdv_pkg::RND_D12)
                        : fdv_pkg::FULL_W'(fdv_pkg::RND_D2));
      qw_c  = d12_1_ff ? (sum_c >>> fdv_pkg::SHIFT_D12) : (sum_c >>> fdv_pkg::SHIFT_D2);
      qw_top = qw_c[fdv_pkg::FULL_W-1:fdv_pkg::Q_W-1];
      if ((&qw_top) || !(|qw_top)) begin
         q2_in = qw_c[fdv_pkg::Q_W-1:0];
      end else if (qw_c[fdv_pkg::FULL_W-1]) begin
         q2_in = fdv_pkg::Q_MIN;
      end else begin
         q2_in = fdv_pkg::Q_MAX;
      end
   end

   // stage 3: offset to non-negative, reciprocal multiply for /3
   assign u_s   = {q2_ff[fdv_pkg::Q_W-1], q2_ff} + fdv_pkg::DIV3_OFFSET;
   assign u_c   = u_s;
   assign ph_in = u_c * fdv_pkg::DIV3_MUL[fdv_pkg::U_W-1:fdv_pkg::DIV3_SPLIT];
   assign pl_in = u_c * fdv_pkg::DIV3_MUL[fdv_pkg::DIV3_SPLIT-1:0];

   // stage 4: derivative
   assign dprod_c = {ph_ff, {fdv_pkg::DIV3_SPLIT{1'b0}}} + fdv_pkg::DPROD_W'(pl_ff);
   assign dv_in   = d12_3_ff
                  ? ($signed(dprod_c[fdv_pkg::DIV3_SHIFT +: fdv_pkg::Q_W]) - fdv_pkg::DIV3_BIAS)
                  : q3_ff;

   // stage 5: velocity with saturation
   always_comb begin
      diff_c   = fdv_pkg::DIFF_W'(bias) - fdv_pkg::DIFF_W'(dv_ff);
      diff_top = diff_c[fdv_pkg::DIFF_W-1:fdv_pkg::POS_W-1];
      if ((&diff_top) || !(|diff_top)) begin
         vel_in = diff_c[fdv_pkg::POS_W-1:0];
      end else if (diff_c[fdv_pkg::DIFF_W-1]) begin
         vel_in = {1'b1, {(fdv_pkg::POS_W-1){1'b0}}};
      end else begin
         vel_in = {1'b0, {(fdv_pkg::POS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      d12_1_ff <= d12;
      q2_ff    <= q2_in;
      d12_2_ff <= d12_1_ff;
      ph_ff    <= ph_in;
      pl_ff    <= pl_in;
      q3_ff    <= q2_ff;
      d12_3_ff <= d12_2_ff;
      dv_ff    <= dv_in;
      vel_ff   <= vel_in;
   end

   assign vel = vel_ff;

endmodule

`default_nettype wire

// File: src/finite_difference_velocity_unit.sv
// Finite-difference velocity unit.
// Request channel (req_*): one position sample of one node per request, with
// req_series_end set on the last sample of the series. Accepted when
// req_valid is high and req_stall is low.
// Response channel (rsp_*): velocity = -(d pos/dt) + (wind, 0, 0) per sample,
// in sample order, two samples late; the last sample flushes three responses.
// Series shorter than three samples give no response.
// Path: a response shows on rsp_valid after the request that completes its
// stencil passes the issue register, 5-stage derivative pipeline and queue.
// Throughput: one request per cycle while req_stall is low; the last sample
// of a series of three or more holds req_stall while the flush responses
// issue through the derivative pipeline.
// Config (csr_*): inv_time_step and wind_speed; write only while idle.
// Reset (synchronous) empties the window, pipeline and response queue and
// restores inv_time_step = 1.0, wind_speed = 0.
// When rsp_stall is high, responses collect in an 8-entry queue; requests
// keep flowing until queue plus pipeline are full, then req_stall rises.
`default_nettype none

module finite_difference_velocity_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   csr_wr_en,
   input  wire logic [fdv_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [31:0]                            csr_wdata,

   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [31:0]                     req_pos_x,
   input  wire logic signed [31:0]                     req_pos_y,
   input  wire logic signed [31:0]                     req_pos_z,
   input  wire logic                                   req_series_end,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [31:0]                          rsp_vel_x,
   output logic signed [31:0]                          rsp_vel_y,
   output logic signed [31:0]                          rsp_vel_z,
   output logic [15:0]                                 rsp_sample_index,
   output logic                                        rsp_final_result
);

   logic [31:0]         inv_ff;
   logic signed [31:0]  wind_ff;

   fdv_pkg::state_type  state_ff, state_in;
   logic [fdv_pkg::IDX_W-1:0] count_ff, count_in;
   logic signed [fdv_pkg::POS_W-1:0] win_ff [fdv_pkg::WIN_DEPTH][fdv_pkg::AXES];
   logic signed [fdv_pkg::POS_W-1:0] pos_new [fdv_pkg::AXES];

   logic                room, req_accept, series_last, rsp_accept;
   logic                issue, issue_fin, win_shift, win_clear, cnt_inc, cnt_clear;
   fdv_pkg::kind_type   issue_kind;
   logic [fdv_pkg::IDX_W-1:0] issue_idx;

   fdv_pkg::meta_type   iss_meta_ff;
   logic signed [fdv_pkg::NUM_W-1:0] iss_num_ff [fdv_pkg::AXES];
   logic                iss_d12_ff;
   fdv_pkg::meta_type   meta_ff [fdv_pkg::DERIV_STAGES];
   logic signed [fdv_pkg::POS_W-1:0] vel [fdv_pkg::AXES];
   logic signed [fdv_pkg::POS_W-1:0] bias [fdv_pkg::AXES];

   fdv_pkg::result_type fifo_mem [fdv_pkg::FIFO_DEPTH];
   fdv_pkg::result_type head;
   logic [fdv_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fdv_pkg::FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in, used_ff, used_in;
   logic                fifo_wr;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff  <= fdv_pkg::INV_TIME_STEP_RESET;
         wind_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fdv_pkg::REG_INV_TIME_STEP: inv_ff  <= csr_wdata;
            fdv_pkg::REG_WIND_SPEED:    wind_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign room        = used_ff != fdv_pkg::FIFO_CNT_W'(fdv_pkg::FIFO_DEPTH);
   assign req_stall   = (state_ff != fdv_pkg::ST_IDLE) || !room;
   assign req_accept  = req_valid && !req_stall;
   assign series_last = req_series_end || (count_ff == fdv_pkg::LAST_INDEX);

   assign pos_new[0] = req_pos_x;
   assign pos_new[1] = req_pos_y;
   assign pos_new[2] = req_pos_z;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdv_pkg::ST_IDLE: begin
            if (req_accept && series_last && count_ff >= fdv_pkg::IDX_W'(2)) begin
               state_in = fdv_pkg::ST_FLUSH_CENTRAL;
            end
         end
         fdv_pkg::ST_FLUSH_CENTRAL: begin
            if (room) begin
               state_in = fdv_pkg::ST_FLUSH_BACKWARD;
            end
         end
         fdv_pkg::ST_FLUSH_BACKWARD: begin
            if (room) begin
               state_in = fdv_pkg::ST_IDLE;
            end
         end
         default: state_in = fdv_pkg::ST_IDLE;
      endcase
   end

   // issue control
   always_comb begin
      issue      = 1'b0;
      issue_kind = fdv_pkg::KIND_CENTRAL;
      issue_idx  = count_ff;
      issue_fin  = 1'b0;
      win_shift  = 1'b0;
      win_clear  = 1'b0;
      cnt_inc    = 1'b0;
      cnt_clear  = 1'b0;
      case (state_ff)
         fdv_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (count_ff >= fdv_pkg::IDX_W'(2)) begin
                  issue     = 1'b1;
                  issue_idx = count_ff - fdv_pkg::IDX_W'(2);
                  if (count_ff == fdv_pkg::IDX_W'(2)) begin
                     issue_kind = fdv_pkg::KIND_FORWARD;
                  end else if (count_ff == fdv_pkg::IDX_W'(3)) begin
                     issue_kind = fdv_pkg::KIND_CENTRAL;
                  end else begin
                     issue_kind = fdv_pkg::KIND_FIVE_POINT;
                  end
               end
               if (series_last && count_ff < fdv_pkg::IDX_W'(2)) begin
                  win_clear = 1'b1;
                  cnt_clear = 1'b1;
               end else begin
                  win_shift = 1'b1;
                  cnt_inc   = !series_last;
               end
            end
         end
         fdv_pkg::ST_FLUSH_CENTRAL: begin
            issue      = room;
            issue_kind = fdv_pkg::KIND_CENTRAL;
            issue_idx  = count_ff - fdv_pkg::IDX_W'(1);
         end
         fdv_pkg::ST_FLUSH_BACKWARD: begin
            issue      = room;
            issue_kind = fdv_pkg::KIND_BACKWARD;
            issue_fin  = 1'b1;
            win_clear  = room;
            cnt_clear  = room;
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cnt_clear) begin
         count_in = '0;
      end else if (cnt_inc) begin
         count_in = count_ff + fdv_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdv_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // sample window, w0 newest
   always_ff @(posedge clock) begin
      if (reset || win_clear) begin
         for (int i = 0; i < fdv_pkg::WIN_DEPTH; i++) begin
            for (int j = 0; j < fdv_pkg::AXES; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (win_shift) begin
         for (int j = 0; j < fdv_pkg::AXES; j++) begin
            win_ff[0][j] <= pos_new[j];
            for (int i = 1; i < fdv_pkg::WIN_DEPTH; i++) begin
               win_ff[i][j] <= win_ff[i-1][j];
            end
         end
      end
   end

   // issue register
   always_ff @(posedge clock) begin
      for (int j = 0; j < fdv_pkg::AXES; j++) begin
         iss_num_ff[j] <= fdv_pkg::stencil_num(issue_kind, pos_new[j], win_ff[0][j],
                                               win_ff[1][j], win_ff[2][j], win_ff[3][j]);
      end
      iss_d12_ff <= issue_kind == fdv_pkg::KIND_FIVE_POINT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_meta_ff <= '0;
         for (int i = 0; i < fdv_pkg::DERIV_STAGES; i++) begin
            meta_ff[i] <= '0;
         end
      end else begin
         iss_meta_ff <= '{valid: issue, idx: issue_idx, fin: issue_fin};
         meta_ff[0]  <= iss_meta_ff;
         for (int i = 1; i < fdv_pkg::DERIV_STAGES; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   assign bias[0] = wind_ff;
   assign bias[1] = '0;
   assign bias[2] = '0;

   for (genvar g = 0; g < fdv_pkg::AXES; g++) begin : g_axis
      fdv_deriv u_deriv (
         .clock    (clock),
         .num      (iss_num_ff[g]),
         .d12      (iss_d12_ff),
         .bias     (bias[g]),
         .inv_step (inv_ff),
         .vel      (vel[g])
      );
   end

   // response queue
   assign fifo_wr    = meta_ff[fdv_pkg::DERIV_STAGES-1].valid;
   assign rsp_valid  = fifo_cnt_ff != '0;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem[wr_ptr_ff] <= '{vel_x: vel[0], vel_y: vel[1], vel_z: vel[2],
                                  idx: meta_ff[fdv_pkg::DERIV_STAGES-1].idx,
                                  fin: meta_ff[fdv_pkg::DERIV_STAGES-1].fin};
      end
   end

   always_comb begin
      case ({fifo_wr, rsp_accept})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + fdv_pkg::FIFO_CNT_W'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - fdv_pkg::FIFO_CNT_W'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
      case ({issue, rsp_accept})
         2'b10:   used_in = used_ff + fdv_pkg::FIFO_CNT_W'(1);
         2'b01:   used_in = used_ff - fdv_pkg::FIFO_CNT_W'(1);
         default: used_in = used_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         used_ff     <= '0;
      end else begin
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + fdv_pkg::FIFO_PTR_W'(1);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + fdv_pkg::FIFO_PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
         used_ff     <= used_in;
      end
   end

   assign head             = fifo_mem[rd_ptr_ff];
   assign rsp_vel_x        = head.vel_x;
   assign rsp_vel_y        = head.vel_y;
   assign rsp_vel_z        = head.vel_z;
   assign rsp_sample_index = head.idx;
   assign rsp_final_result = head.fin;

endmodule

`default_nettype wire

// File: bench/finite_difference_velocity_unit_tb.sv
`timescale 1ns / 100ps

module finite_difference_velocity_unit_tb;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               series_end;
   } sample_type;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_EXTREME,
      STYLE_SMOOTH
   } pos_style_type;

   localparam int LIMIT_CYCLES = 100_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 90;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_wr_en = 1'b0;
   logic [fdv_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_wdata = '0;

   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x      = '0;
   logic signed [31:0] req_pos_y      = '0;
   logic signed [31:0] req_pos_z      = '0;
   logic               req_series_end = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_vel_x;
   logic signed [31:0] rsp_vel_y;
   logic signed [31:0] rsp_vel_z;
   logic [15:0]        rsp_sample_index;
   logic               rsp_final_result;

   finite_difference_velocity_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_series_end   (req_series_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vel_x        (rsp_vel_x),
      .rsp_vel_y        (rsp_vel_y),
      .rsp_vel_z        (rsp_vel_z),
      .rsp_sample_index (rsp_sample_index),
      .rsp_final_result (rsp_final_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sample_type          pending_samples[$];
   sample_type          offered_sample;
   fdv_pkg::result_type expected_velocity[$];
   int                  mismatch_count = 0;
   int                  requests_taken = 0;
   int                  hold_left      = 0;
   bit                  hold_done      = 1'b0;
   logic                quiet;

   assign quiet = (requests_taken >= 260) && (requests_taken < 380);

   // predictor state
   longint step_scale;
   longint wind_x;
   longint history[0:3][0:2];
   longint taps[0:4][0:2];
   int     samples_in_series;

   function automatic longint floor_quot(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scaled_slope(longint num, longint divisor);
      longint hi, lo;
      hi = step_scale >> 16;
      lo = step_scale & 64'hFFFF;
      return floor_quot(num * hi + floor_quot(num * lo + 32768 * divisor, 65536), divisor);
   endfunction

   // c is the tap holding pos[t]
   function automatic void push_velocity(int c, fdv_pkg::kind_type kind, int t, bit fin);
      fdv_pkg::result_type r;
      longint              num, divisor, v;
      logic signed [31:0]  vel[0:2];
      for (int j = 0; j < 3; j++) begin
         case (kind)
            fdv_pkg::KIND_FORWARD: begin
               num = -taps[c+2][j] + 4 * taps[c+1][j] - 3 * taps[c][j];
               divisor = 2;
            end
            fdv_pkg::KIND_CENTRAL: begin
               num = taps[c+1][j] - taps[c-1][j];
               divisor = 2;
            end
            fdv_pkg::KIND_FIVE_POINT: begin
               num = -taps[c+2][j] + 8 * taps[c+1][j] - 8 * taps[c-1][j] + taps[c-2][j];
               divisor = 12;
            end
            default: begin
               num = 3 * taps[c][j] - 4 * taps[c-1][j] + taps[c-2][j];
               divisor = 2;
            end
         endcase
         v = clamp32(((j == 0) ? wind_x : 64'sd0) - scaled_slope(num, divisor));
         vel[j] = v[31:0];
      end
      r.vel_x = vel[0];
      r.vel_y = vel[1];
      r.vel_z = vel[2];
      r.idx   = t[15:0];
      r.fin   = fin;
      expected_velocity.push_back(r);
   endfunction

   function automatic void predict_velocity(sample_type smp);
      int                k;
      bit                last;
      fdv_pkg::kind_type kind;
      k = samples_in_series;
      last = smp.series_end || (k + 1 >= fdv_pkg::SAMPLE_LIMIT);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3; j++)
            taps[3-i][j] = history[i][j];
      taps[4][0] = smp.x;
      taps[4][1] = smp.y;
      taps[4][2] = smp.z;
      if (k >= 2) begin
         if (k == 2) kind = fdv_pkg::KIND_FORWARD;
         else if (k == 3) kind = fdv_pkg::KIND_CENTRAL;
         else kind = fdv_pkg::KIND_FIVE_POINT;
         push_velocity(2, kind, k - 2, 1'b0);
         if (last) begin
            push_velocity(3, fdv_pkg::KIND_CENTRAL, k - 1, 1'b0);
            push_velocity(4, fdv_pkg::KIND_BACKWARD, k, 1'b1);
         end
      end
      if (last) begin
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
               history[i][j] = 0;
         samples_in_series = 0;
      end else begin
         for (int i = 3; i > 0; i--)
            for (int j = 0; j < 3; j++)
               history[i][j] = history[i-1][j];
         for (int j = 0; j < 3; j++)
            history[0][j] = taps[4][j];
         samples_in_series = k + 1;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %08h, got %08h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void queue_series(int len, pos_style_type style, bit closed);
      sample_type         smp;
      logic signed [31:0] base[0:2];
      logic signed [31:0] drift[0:2];
      for (int j = 0; j < 3; j++) begin
         base[j]  = $signed($urandom) >>> 3;
         drift[j] = $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
      end
      for (int i = 0; i < len; i++) begin
         case (style)
            STYLE_EXTREME: begin
               smp.x = i[0] ? POS_MIN : POS_MAX;
               smp.y = i[0] ? POS_MAX : POS_MIN;
               case (i % 5)
                  0:       smp.z = '0;
                  1:       smp.z = POS_MAX;
                  2:       smp.z = -32'sd1;
                  3:       smp.z = POS_MIN;
                  default: smp.z = 32'sd1;
               endcase
            end
            STYLE_SMOOTH: begin
               for (int j = 0; j < 3; j++)
                  base[j] = base[j] + drift[j] + $signed($urandom_range(255, 0)) - 128;
               smp.x = base[0];
               smp.y = base[1];
               smp.z = base[2];
            end
            default: begin
               smp.x = $urandom;
               smp.y = $urandom;
               smp.z = $urandom;
            end
         endcase
         smp.series_end = closed && (i == len - 1);
         pending_samples.push_back(smp);
      end
   endfunction

   task automatic write_csr(input logic [fdv_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == fdv_pkg::REG_INV_TIME_STEP) step_scale = longint'(data);
      else wind_x = longint'($signed(data));
   endtask

   // series can end with requests that produce nothing, so pad past the pipeline
   task automatic settle();
      while (pending_samples.size() != 0 || req_valid || expected_velocity.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_velocity(offered_sample);
            requests_taken <= requests_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && (quiet || $urandom_range(99, 0) >= 37)) begin
               offered_sample = pending_samples.pop_front();
               req_pos_x      <= offered_sample.x;
               req_pos_y      <= offered_sample.y;
               req_pos_z      <= offered_sample.z;
               req_series_end <= offered_sample.series_end;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long hold-off so the result queue fills and back-pressures requests
   always @(posedge clock) begin : hold_off
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && requests_taken >= 60) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      fdv_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_velocity.size() == 0) begin
               $error("unexpected response, sample_index %0d", rsp_sample_index);
               mismatch_count++;
            end else begin
               want = expected_velocity.pop_front();
               check_field("vel_x", want.vel_x, rsp_vel_x);
               check_field("vel_y", want.vel_y, rsp_vel_y);
               check_field("vel_z", want.vel_z, rsp_vel_z);
               check_field("sample_index", 32'(want.idx), 32'(rsp_sample_index));
               check_field("final_result", 32'(want.fin), 32'(rsp_final_result));
            end
         end
         rsp_stall <= (hold_left != 0) || (!quiet && $urandom_range(99, 0) < 37);
      end
   end

   initial begin : stimulus
      logic [31:0] inv_cfg[0:4];
      logic [31:0] wind_cfg[0:4];
      int          queued;
      int          len;
      int          pick;
      step_scale = longint'(fdv_pkg::INV_TIME_STEP_RESET);
      wind_x = 0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3; j++)
            history[i][j] = 0;
      samples_in_series = 0;
      inv_cfg[0]  = 32'hFFFF_FFFF;
      wind_cfg[0] = 32'h7FFF_FFFF;
      inv_cfg[1]  = 32'h0000_0000;
      wind_cfg[1] = 32'h8000_0000;
      inv_cfg[2]  = $urandom_range(32'h0004_0000, 32'h0000_4000);
      wind_cfg[2] = $urandom;
      inv_cfg[3]  = $urandom;
      wind_cfg[3] = $urandom;
      inv_cfg[4]  = 32'h0001_0000;
      wind_cfg[4] = 32'hFFFF_0000;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // short series first: one and two samples give nothing
      for (int n = 1; n <= 6; n++)
         queue_series(n, STYLE_EXTREME, 1'b1);
      queue_series(3, STYLE_SMOOTH, 1'b1);
      settle();

      for (int p = 0; p < 5; p++) begin
         write_csr(fdv_pkg::REG_INV_TIME_STEP, inv_cfg[p]);
         write_csr(fdv_pkg::REG_WIND_SPEED, wind_cfg[p]);
         queued = 0;
         while (queued < 100) begin
            pick = $urandom_range(99, 0);
            if (pick < 10) len = $urandom_range(2, 1);
            else if (pick < 15) len = $urandom_range(40, 13);
            else len = $urandom_range(12, 3);
            queue_series(len, pos_style_type'($urandom_range(2, 0)), 1'b1);
            queued += len;
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(64'd8 * LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

endmodule
